FILE: src/age_priority_queue_macros.svh
// Assertion macros shared by the queue RTL.
// Each macro takes a label, clock, reset, antecedent and consequent.
`ifndef AGE_PRIORITY_QUEUE_MACROS_SVH
`define AGE_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// consequent holds in the same cycle
`define APQ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("age_priority_queue: same-cycle check failed");
// consequent holds in the next cycle
`define APQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("age_priority_queue: next-cycle check failed");
`else
`define APQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define APQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: src/apq_pkg.sv
package apq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TAG_W       = 16;
  localparam int AGE_W       = 8;
  localparam int PRIO_W      = 3;
  localparam int SERVED_W    = 16;

  // mode codes
  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_DEQ  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // age tier thresholds
  localparam logic [AGE_W-1:0] AGE_TIER1 = 8'd60;
  localparam logic [AGE_W-1:0] AGE_TIER2 = 8'd70;
  localparam logic [AGE_W-1:0] AGE_TIER3 = 8'd80;
  localparam logic [AGE_W-1:0] AGE_TIER4 = 8'd90;
  localparam logic [AGE_W-1:0] AGE_TIER5 = 8'd100;

  typedef struct packed {
    logic [1:0]       mode;
    logic [TAG_W-1:0] person_tag;
    logic [AGE_W-1:0] age;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [TAG_W-1:0]    head_tag;
    logic [AGE_W-1:0]    head_age;
    logic [PRIO_W-1:0]   head_priority;
    logic [4:0]          occupancy;
    logic [SERVED_W-1:0] served_normal;
    logic [SERVED_W-1:0] served_priority;
    logic [4:0]          waiting_normal;
    logic [4:0]          waiting_priority;
  } out_t;

  // one stored queue entry
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [AGE_W-1:0]  age;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_entry;
  } cell_cmd_t;

  function automatic logic [PRIO_W-1:0] age_to_prio(input logic [AGE_W-1:0] a);
    logic [PRIO_W-1:0] p;
    if (a >= AGE_TIER5)      p = 3'd5;
    else if (a >= AGE_TIER4) p = 3'd4;
    else if (a >= AGE_TIER3) p = 3'd3;
    else if (a >= AGE_TIER2) p = 3'd2;
    else if (a >= AGE_TIER1) p = 3'd1;
    else                     p = 3'd0;
    return p;
  endfunction

endpackage

FILE: src/apq_cell.sv
// One slot of the sorted chain. Holds an entry and decides locally whether
// to keep it, take the new entry, take its upper neighbor or its lower one.
module apq_cell (
  input  logic               clk,
  input  logic               rst,
  input  apq_pkg::cell_cmd_t cmd,
  input  logic               prev_here,
  input  logic               prev_valid,
  input  apq_pkg::entry_t    prev_entry,
  input  logic               next_valid,
  input  apq_pkg::entry_t    next_entry,
  output logic               here,
  output logic               valid,
  output apq_pkg::entry_t    entry
);

  // insertion point lies at or above this slot
  assign here = !valid || (entry.prio < cmd.new_entry.prio);

  // occupancy bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.deq) begin
      valid <= next_valid;
    end else if (cmd.enq && here) begin
      valid <= prev_here ? prev_valid : 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.deq) begin
      entry <= next_entry;
    end else if (cmd.enq && here) begin
      entry <= prev_here ? prev_entry : cmd.new_entry;
    end
  end

endmodule

FILE: src/apq_chain.sv
// Row of cells kept sorted by priority, oldest first within a priority.
// Slot 0 is the head.
module apq_chain (
  input  logic               clk,
  input  logic               rst,
  input  apq_pkg::cell_cmd_t cmd,
  output apq_pkg::entry_t    head,
  output logic               head_valid,
  output logic               full
);

  localparam int D = apq_pkg::QUEUE_DEPTH;

  // neighbor links, padded at both ends
  logic            here_ext  [0:D];
  logic            valid_ext [0:D+1];
  apq_pkg::entry_t entry_ext [0:D+1];

  assign here_ext[0]    = 1'b0;
  assign valid_ext[0]   = 1'b0;
  assign entry_ext[0]   = '0;
  assign valid_ext[D+1] = 1'b0;
  assign entry_ext[D+1] = '0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    apq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .prev_here  (here_ext[i]),
      .prev_valid (valid_ext[i]),
      .prev_entry (entry_ext[i]),
      .next_valid (valid_ext[i+2]),
      .next_entry (entry_ext[i+2]),
      .here       (here_ext[i+1]),
      .valid      (valid_ext[i+1]),
      .entry      (entry_ext[i+1])
    );
  end

  assign head       = entry_ext[1];
  assign head_valid = valid_ext[1];
  assign full       = valid_ext[D];

endmodule

FILE: src/age_priority_queue.sv
// Timing: a result beat appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the receiver takes each result; every cell of the chain
// compares and shifts in the same cycle, and the registered result frees as soon as it is taken.
// Reset: synchronous, clears the cell valid bits and all counters; cell
// payload is not reset and is never read while its slot is empty.
`include "age_priority_queue_macros.svh"

module age_priority_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  apq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output apq_pkg::out_t out_data
);

  localparam int CW = apq_pkg::CNT_W;
  localparam int SW = apq_pkg::SERVED_W;
  localparam logic [CW-1:0] DEPTH_CNT = CW'(apq_pkg::QUEUE_DEPTH);
  localparam logic [SW-1:0] SERVED_MAX = '1;

  logic               accept;
  logic               is_enq, is_deq, is_peek;
  logic               enq_ok, deq_ok;
  logic               full, head_valid;
  apq_pkg::entry_t    head;
  apq_pkg::cell_cmd_t cmd;
  apq_pkg::out_t      result;

  logic [CW-1:0] count, count_next;
  logic [SW-1:0] served_normal, served_normal_next;
  logic [SW-1:0] served_priority, served_priority_next;
  logic [CW-1:0] waiting_normal, waiting_normal_next;
  logic [CW-1:0] waiting_priority, waiting_priority_next;

  // handshake
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // decode
  assign is_enq  = (in_data.mode == apq_pkg::MODE_ENQ);
  assign is_deq  = (in_data.mode == apq_pkg::MODE_DEQ);
  assign is_peek = (in_data.mode == apq_pkg::MODE_PEEK);
  assign enq_ok  = accept && is_enq && !full;
  assign deq_ok  = accept && is_deq && head_valid;

  // chain command
  always_comb begin
    cmd                     = '0;
    cmd.enq                 = enq_ok;
    cmd.deq                 = deq_ok;
    cmd.new_entry.tag       = in_data.person_tag;
    cmd.new_entry.age       = in_data.age;
    cmd.new_entry.prio      = apq_pkg::age_to_prio(in_data.age);
  end

  apq_chain u_chain (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  // counter updates
  always_comb begin
    count_next            = count;
    served_normal_next    = served_normal;
    served_priority_next  = served_priority;
    waiting_normal_next   = waiting_normal;
    waiting_priority_next = waiting_priority;
    if (enq_ok) begin
      count_next = count + 1'b1;
      if (cmd.new_entry.prio == '0) waiting_normal_next = waiting_normal + 1'b1;
      else                           waiting_priority_next = waiting_priority + 1'b1;
    end else if (deq_ok) begin
      count_next = count - 1'b1;
      if (head.prio == '0) begin
        if (served_normal != SERVED_MAX) served_normal_next = served_normal + 1'b1;
        if (waiting_normal != '0) waiting_normal_next = waiting_normal - 1'b1;
      end else begin
        if (served_priority != SERVED_MAX) served_priority_next = served_priority + 1'b1;
        if (waiting_priority != '0) waiting_priority_next = waiting_priority - 1'b1;
      end
    end
  end

  // result beat
  always_comb begin
    result        = '0;
    result.status = apq_pkg::STATUS_OK;
    if (is_enq && full) begin
      result.status = apq_pkg::STATUS_FULL;
    end else if ((is_deq || is_peek) && !head_valid) begin
      result.status = apq_pkg::STATUS_EMPTY;
    end else if (is_deq || is_peek) begin
      result.head_tag      = head.tag;
      result.head_age      = head.age;
      result.head_priority = head.prio;
    end
    result.occupancy        = 5'(count_next);
    result.served_normal    = served_normal_next;
    result.served_priority  = served_priority_next;
    result.waiting_normal   = 5'(waiting_normal_next);
    result.waiting_priority = 5'(waiting_priority_next);
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count            <= '0;
      served_normal    <= '0;
      served_priority  <= '0;
      waiting_normal   <= '0;
      waiting_priority <= '0;
    end else begin
      count            <= count_next;
      served_normal    <= served_normal_next;
      served_priority  <= served_priority_next;
      waiting_normal   <= waiting_normal_next;
      waiting_priority <= waiting_priority_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  // class counts always add up to the chain occupancy
  `APQ_ASSERT_SAME(a_class_sum, clk, rst, 1'b1, (({1'b0, waiting_normal} + {1'b0, waiting_priority}) == {1'b0, count}))
  // head slot filled exactly when the count is nonzero
  `APQ_ASSERT_SAME(a_head_matches_count, clk, rst, 1'b1, (head_valid == (count != '0)))
  // last slot filled exactly when the count is at depth
  `APQ_ASSERT_SAME(a_full_matches_count, clk, rst, 1'b1, (full == (count == DEPTH_CNT)))
  // a served dequeue drops the count by one
  `APQ_ASSERT_NEXT(a_deq_shrinks, clk, rst, deq_ok, (count == ($past(count) - 1'b1)))
  // a stored enqueue grows the count by one
  `APQ_ASSERT_NEXT(a_enq_grows, clk, rst, enq_ok, (count == ($past(count) + 1'b1)))

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  // code the block leaves unused; it must pass through as a no-op
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BEATS    = 215;

  // Priority queue predictor plus the FIFO of expected result beats.
  class queue_scoreboard;
    apq_pkg::entry_t              slots[apq_pkg::QUEUE_DEPTH];
    int unsigned                  fill;
    logic [apq_pkg::SERVED_W-1:0] served_norm;
    logic [apq_pkg::SERVED_W-1:0] served_prio;
    logic [4:0]                   wait_norm;
    logic [4:0]                   wait_prio;
    apq_pkg::out_t                expected_q[$];
    int unsigned                  mismatches;

    function new();
      fill        = 0;
      served_norm = '0;
      served_prio = '0;
      wait_norm   = '0;
      wait_prio   = '0;
      mismatches  = 0;
    endfunction

    // below 60 is class 0, 100 and up is 5, each decade between is one step
    function logic [apq_pkg::PRIO_W-1:0] tier_of(logic [apq_pkg::AGE_W-1:0] a);
      logic [apq_pkg::PRIO_W-1:0] t;
      if (a < apq_pkg::AGE_TIER1) t = '0;
      else if (a >= apq_pkg::AGE_TIER5) t = 3'd5;
      else t = apq_pkg::PRIO_W'((a - 8'd50) / 8'd10);
      return t;
    endfunction

    // an input beat was accepted: update the queue image, queue the expected result
    function void note_request(apq_pkg::in_t req);
      apq_pkg::out_t              exp;
      int unsigned                pos;
      logic [apq_pkg::PRIO_W-1:0] p;
      exp = '0;
      case (req.mode)
        apq_pkg::MODE_ENQ: begin
          if (fill == apq_pkg::QUEUE_DEPTH) begin
            exp.status = apq_pkg::STATUS_FULL;
          end else begin
            p   = tier_of(req.age);
            pos = fill;
            // new entry goes behind everything of equal or higher class
            while (pos > 0 && slots[pos-1].prio < p) begin
              slots[pos] = slots[pos-1];
              pos--;
            end
            slots[pos].tag  = req.person_tag;
            slots[pos].age  = req.age;
            slots[pos].prio = p;
            fill++;
            if (p == 0) wait_norm++;
            else wait_prio++;
          end
        end
        apq_pkg::MODE_DEQ, apq_pkg::MODE_PEEK: begin
          if (fill == 0) begin
            exp.status = apq_pkg::STATUS_EMPTY;
          end else begin
            exp.head_tag      = slots[0].tag;
            exp.head_age      = slots[0].age;
            exp.head_priority = slots[0].prio;
            if (req.mode == apq_pkg::MODE_DEQ) begin
              if (slots[0].prio == 0) begin
                if (served_norm != '1) served_norm++;
                wait_norm--;
              end else begin
                if (served_prio != '1) served_prio++;
                wait_prio--;
              end
              for (int i = 1; i < fill; i++) slots[i-1] = slots[i];
              fill--;
            end
          end
        end
        default: ;
      endcase
      exp.occupancy        = 5'(fill);
      exp.served_normal    = served_norm;
      exp.served_priority  = served_prio;
      exp.waiting_normal   = wait_norm;
      exp.waiting_priority = wait_prio;
      expected_q.push_back(exp);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    // a result beat was accepted: compare against the oldest expectation
    function void check_response(apq_pkg::out_t got);
      apq_pkg::out_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result beat: expected none, got %h", $time, got);
      end else begin
        exp = expected_q.pop_front();
        compare_field("status", exp.status, got.status);
        compare_field("head_tag", exp.head_tag, got.head_tag);
        compare_field("head_age", exp.head_age, got.head_age);
        compare_field("head_priority", exp.head_priority, got.head_priority);
        compare_field("occupancy", exp.occupancy, got.occupancy);
        compare_field("served_normal", exp.served_normal, got.served_normal);
        compare_field("served_priority", exp.served_priority, got.served_priority);
        compare_field("waiting_normal", exp.waiting_normal, got.waiting_normal);
        compare_field("waiting_priority", exp.waiting_priority, got.waiting_priority);
      end
    endfunction
  endclass

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  apq_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  apq_pkg::out_t out_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  queue_scoreboard sb = new();

  age_priority_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver backpressure, changed on the falling edge
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // beat monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_response(out_data);
    end
  end

  // watchdog: too long without any beat on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  function automatic apq_pkg::in_t beat_of(logic [1:0] mode,
                                           logic [apq_pkg::TAG_W-1:0] tag,
                                           logic [apq_pkg::AGE_W-1:0] age);
    apq_pkg::in_t b;
    b.mode       = mode;
    b.person_tag = tag;
    b.age        = age;
    return b;
  endfunction

  // Called and returns at a falling edge; valid is left high after the beat.
  task automatic send_beat(input apq_pkg::in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // mostly ages around the class boundaries, some over the full range
  function automatic logic [apq_pkg::AGE_W-1:0] random_age();
    if ($urandom_range(99) < 30) return apq_pkg::AGE_W'($urandom_range(0, 255));
    return apq_pkg::AGE_W'($urandom_range(50, 109));
  endfunction

  // random traffic; the mix swings between filling and draining
  task automatic run_phase(input int idle_pct, input int stall_pct, input int beats);
    int r;
    int enq_w;
    int deq_w;
    logic [1:0] mode;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < beats; k++) begin
      enq_w = ((k / 40) % 2 == 0) ? 60 : 20;
      deq_w = 80 - enq_w;
      r = $urandom_range(99);
      if (r < enq_w) mode = apq_pkg::MODE_ENQ;
      else if (r < enq_w + deq_w) mode = apq_pkg::MODE_DEQ;
      else if (r < 95) mode = apq_pkg::MODE_PEEK;
      else mode = MODE_IGNORED;
      send_beat(beat_of(mode, apq_pkg::TAG_W'($urandom_range(0, 65535)), random_age()));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed: empty queue, every class boundary, full queue, head reads
    send_beat(beat_of(apq_pkg::MODE_DEQ, 16'h1234, 8'd77));
    send_beat(beat_of(apq_pkg::MODE_PEEK, 16'h4321, 8'd12));
    send_beat(beat_of(MODE_IGNORED, 16'hFFFF, 8'd255));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'h0000, 8'd0));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'h0001, 8'd59));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'h0002, 8'd60));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'h0003, 8'd69));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'h0004, 8'd70));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'h0005, 8'd79));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'h0006, 8'd80));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'h0007, 8'd89));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'h0008, 8'd90));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'h0009, 8'd99));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'hA5A5, 8'd100));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'hFFFF, 8'd255));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'h5A5A, 8'd59));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'h8000, 8'd100));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'h7FFF, 8'd60));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'hC3C3, 8'd0));
    send_beat(beat_of(apq_pkg::MODE_ENQ, 16'hFFFF, 8'd255));
    send_beat(beat_of(MODE_IGNORED, 16'h0000, 8'd0));
    send_beat(beat_of(apq_pkg::MODE_PEEK, 16'h0000, 8'd0));
    send_beat(beat_of(apq_pkg::MODE_DEQ, 16'h0000, 8'd0));
    send_beat(beat_of(apq_pkg::MODE_DEQ, 16'hFFFF, 8'd255));

    // random traffic under each idling pattern
    run_phase(0, 0, PHASE_BEATS);
    run_phase(68, 0, PHASE_BEATS);
    run_phase(0, 68, PHASE_BEATS);
    run_phase(6, 6, PHASE_BEATS);
    in_valid = 1'b0;

    // drain, then a few quiet cycles to catch stray result beats
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (sb.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/apq_pkg.sv
src/apq_cell.sv
src/apq_chain.sv
src/age_priority_queue.sv
tb/tb.sv
